@@ rtl/klpd_pkg.sv @@
package klpd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 16;
  localparam int CFG_BITS = 16;
  localparam int ACCUM_BITS = 17;
  localparam int PROD_BITS = 21;
  localparam int KIND_BITS = 3;
  localparam int KW_COUNT = 5;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;
  localparam logic [0:0] REG_MAX_LENGTH = 1'd0;
  localparam logic [CFG_BITS-1:0] MAX_LENGTH_RESET = 16'hFFFF;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [2:0] DIGIT_LIMIT = 3'd7;
  localparam logic [2:0] KEYWORD_LETTERS = 3'd4;
  localparam logic [ACCUM_BITS-1:0] ACCUM_MAX = 17'h1FFFF;

  localparam logic [1:0] OUT_PAYLOAD = 2'd0;
  localparam logic [1:0] OUT_EMPTY = 2'd1;
  localparam logic [1:0] OUT_ERROR = 2'd2;

  localparam logic [KIND_BITS-1:0] FK_PING = 3'd0;
  localparam logic [KIND_BITS-1:0] FK_PONG = 3'd1;
  localparam logic [KIND_BITS-1:0] FK_NICK = 3'd2;
  localparam logic [KIND_BITS-1:0] FK_LIST = 3'd3;
  localparam logic [KIND_BITS-1:0] FK_CHAT = 3'd4;

  localparam logic [31:0] KEYWORD_TABLE [KW_COUNT] = '{
    32'h50494E47,
    32'h504F4E47,
    32'h4E49434B,
    32'h4C495354,
    32'h43484154
  };

  typedef struct packed {
    logic [1:0] out_kind;
    logic [KIND_BITS-1:0] frame_kind;
    logic [7:0] data_byte;
    logic last_byte;
    logic link_ready;
  } result_t;

  typedef struct packed {
    logic valid;
    result_t data;
  } res_push_t;

  typedef struct packed {
    logic hit;
    logic [KIND_BITS-1:0] kind;
  } kw_hit_t;

  function automatic kw_hit_t kw_lookup(input logic [31:0] word);
    kw_hit_t r;
    r.hit = 1'b0;
    r.kind = FK_PING;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      if (KEYWORD_TABLE[i] == word) begin
        r.hit = 1'b1;
        r.kind = KIND_BITS'(i);
      end
    end
    return r;
  endfunction

endpackage

@@ rtl/klpd_in_if.sv @@
interface klpd_in_if;
  logic valid;
  logic ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/klpd_out_if.sv @@
interface klpd_out_if;
  logic valid;
  logic ready;
  logic [1:0] out_kind;
  logic [klpd_pkg::KIND_BITS-1:0] frame_kind;
  logic [7:0] data_byte;
  logic last_byte;
  logic link_ready;

  modport source (output valid, output out_kind, output frame_kind, output data_byte,
                  output last_byte, output link_ready, input ready);
  modport sink (input valid, input out_kind, input frame_kind, input data_byte,
                input last_byte, input link_ready, output ready);
endinterface

@@ rtl/klpd_apb_regs.sv @@
module klpd_apb_regs (
  input  logic clk,
  input  logic rst,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [klpd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [klpd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [klpd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready,
  output logic [klpd_pkg::CFG_BITS-1:0] max_length
);

  logic [0:0] reg_index;
  logic wr_en;

  assign reg_index = paddr[klpd_pkg::APB_ADDR_BITS-1:2];
  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= klpd_pkg::MAX_LENGTH_RESET;
    end else if (wr_en && reg_index == klpd_pkg::REG_MAX_LENGTH) begin
      max_length <= pwdata[klpd_pkg::CFG_BITS-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == klpd_pkg::REG_MAX_LENGTH) begin
      prdata = klpd_pkg::APB_DATA_BITS'(max_length);
    end
  end

endmodule

@@ rtl/klpd_parser.sv @@
module klpd_parser #(
  parameter int LENGTH_BITS = klpd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic accept,
  input  logic [7:0] rx_byte,
  input  logic [klpd_pkg::CFG_BITS-1:0] max_length,
  output klpd_pkg::res_push_t push
);

  localparam int CNT_BITS = (LENGTH_BITS < klpd_pkg::CFG_BITS) ? LENGTH_BITS
                                                                 : klpd_pkg::CFG_BITS;
  localparam logic [klpd_pkg::CFG_BITS-1:0] LEN_CAP_MAX =
    (LENGTH_BITS >= klpd_pkg::CFG_BITS) ? {klpd_pkg::CFG_BITS{1'b1}}
                                        : klpd_pkg::CFG_BITS'((64'd1 << LENGTH_BITS) - 64'd1);

  typedef enum logic [1:0] {
    PH_KEYWORD,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_ERROR
  } phase_t;

  phase_t phase, phase_next;
  logic [31:0] keyword_shift, keyword_shift_next;
  logic [2:0] keyword_count, keyword_count_next;
  logic [klpd_pkg::ACCUM_BITS-1:0] length_accum, length_accum_next;
  logic [2:0] length_digits, length_digits_next;
  logic [CNT_BITS-1:0] bytes_left, bytes_left_next;
  logic [klpd_pkg::KIND_BITS-1:0] current_kind, current_kind_next;
  logic list_seen, list_seen_next;

  logic [klpd_pkg::CFG_BITS-1:0] len_cap;
  logic [klpd_pkg::PROD_BITS-1:0] accum_prod;
  logic [CNT_BITS-1:0] bytes_dec;
  klpd_pkg::kw_hit_t kw;

  assign len_cap = (max_length < LEN_CAP_MAX) ? max_length : LEN_CAP_MAX;
  assign accum_prod = klpd_pkg::PROD_BITS'({length_accum, 3'b000})
                    + klpd_pkg::PROD_BITS'({length_accum, 1'b0})
                    + klpd_pkg::PROD_BITS'(rx_byte[3:0]);
  assign bytes_dec = bytes_left - CNT_BITS'(1);
  assign kw = klpd_pkg::kw_lookup(keyword_shift);

  always_comb begin
    phase_next = phase;
    keyword_shift_next = keyword_shift;
    keyword_count_next = keyword_count;
    length_accum_next = length_accum;
    length_digits_next = length_digits;
    bytes_left_next = bytes_left;
    current_kind_next = current_kind;
    list_seen_next = list_seen;
    push.valid = 1'b0;
    push.data.out_kind = klpd_pkg::OUT_ERROR;
    push.data.frame_kind = current_kind;
    push.data.data_byte = '0;
    push.data.last_byte = 1'b0;

    if (accept) begin
      case (phase)
        PH_KEYWORD: begin
          if (rx_byte == klpd_pkg::SPACE_CHAR) begin
            if (keyword_count == klpd_pkg::KEYWORD_LETTERS && kw.hit) begin
              current_kind_next = kw.kind;
              phase_next = PH_LENGTH;
              length_accum_next = '0;
              length_digits_next = '0;
            end else begin
              phase_next = PH_ERROR;
              push.valid = 1'b1;
              push.data.frame_kind = klpd_pkg::FK_PING;
            end
          end else if (keyword_count >= klpd_pkg::KEYWORD_LETTERS) begin
            phase_next = PH_ERROR;
            push.valid = 1'b1;
            push.data.frame_kind = klpd_pkg::FK_PING;
          end else begin
            keyword_shift_next = {keyword_shift[23:0], rx_byte};
            keyword_count_next = keyword_count + 3'd1;
          end
        end
        PH_LENGTH: begin
          if (rx_byte inside {[klpd_pkg::DIGIT_ZERO:klpd_pkg::DIGIT_NINE]}) begin
            if (length_digits >= klpd_pkg::DIGIT_LIMIT) begin
              phase_next = PH_ERROR;
              push.valid = 1'b1;
            end else begin
              length_digits_next = length_digits + 3'd1;
              if (accum_prod > klpd_pkg::PROD_BITS'(klpd_pkg::ACCUM_MAX)) begin
                length_accum_next = klpd_pkg::ACCUM_MAX;
              end else begin
                length_accum_next = accum_prod[klpd_pkg::ACCUM_BITS-1:0];
              end
            end
          end else if (rx_byte != klpd_pkg::SPACE_CHAR) begin
            phase_next = PH_ERROR;
            push.valid = 1'b1;
          end else if (length_accum > klpd_pkg::ACCUM_BITS'(len_cap)) begin
            phase_next = PH_ERROR;
            push.valid = 1'b1;
          end else if (length_accum == '0) begin
            if (current_kind == klpd_pkg::FK_LIST) begin
              list_seen_next = 1'b1;
            end
            push.valid = 1'b1;
            push.data.out_kind = klpd_pkg::OUT_EMPTY;
            push.data.last_byte = 1'b1;
            phase_next = PH_KEYWORD;
            keyword_shift_next = '0;
            keyword_count_next = '0;
            length_accum_next = '0;
            length_digits_next = '0;
          end else begin
            bytes_left_next = length_accum[CNT_BITS-1:0];
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          bytes_left_next = bytes_dec;
          push.valid = 1'b1;
          push.data.out_kind = klpd_pkg::OUT_PAYLOAD;
          push.data.data_byte = rx_byte;
          push.data.last_byte = (bytes_dec == '0);
          if (bytes_dec == '0) begin
            if (current_kind == klpd_pkg::FK_LIST) begin
              list_seen_next = 1'b1;
            end
            phase_next = PH_KEYWORD;
            keyword_shift_next = '0;
            keyword_count_next = '0;
            length_accum_next = '0;
            length_digits_next = '0;
          end
        end
        default: begin
        end
      endcase
    end
    push.data.link_ready = list_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_KEYWORD;
      keyword_shift <= '0;
      keyword_count <= '0;
      length_accum <= '0;
      length_digits <= '0;
      bytes_left <= '0;
      current_kind <= '0;
      list_seen <= 1'b0;
    end else begin
      phase <= phase_next;
      keyword_shift <= keyword_shift_next;
      keyword_count <= keyword_count_next;
      length_accum <= length_accum_next;
      length_digits <= length_digits_next;
      bytes_left <= bytes_left_next;
      current_kind <= current_kind_next;
      list_seen <= list_seen_next;
    end
  end

endmodule

@@ rtl/klpd_out_buf.sv @@
module klpd_out_buf (
  input  logic clk,
  input  logic rst,
  input  klpd_pkg::res_push_t push,
  output logic can_accept,
  klpd_out_if.source res
);

  klpd_pkg::result_t e0, e1;
  logic [1:0] cnt;
  logic pop;

  assign pop = res.valid & res.ready;
  assign can_accept = (cnt != 2'd2) | res.ready;

  assign res.valid = (cnt != 2'd0);
  assign res.out_kind = e0.out_kind;
  assign res.frame_kind = e0.frame_kind;
  assign res.data_byte = e0.data_byte;
  assign res.last_byte = e0.last_byte;
  assign res.link_ready = e0.link_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + {1'b0, push.valid} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && cnt == 2'd2) begin
      e0 <= e1;
    end
    if (push.valid) begin
      if (cnt == 2'd0 || (cnt == 2'd1 && pop)) begin
        e0 <= push.data;
      end else begin
        e1 <= push.data;
      end
    end
  end

endmodule

@@ rtl/keyword_length_payload_deframer_unit.sv @@
// Keyword/length/payload deframer.
// rx carries one received link byte per transaction. Frames are a four-letter
// keyword (PING, PONG, NICK, LIST, CHAT), a space, a decimal length, a space,
// then that many payload bytes.
// res carries one result per payload byte (with frame kind and last flag), one
// for each empty frame, and one when a framing fault enters the error state.
// link_ready in each result is set once a LIST frame has completed.
// Throughput: one byte per cycle while rx.ready is high; the parser state updates in the accept cycle.
// Results: each result is written into the result buffer and presented on res from its head entry.
// Stall: a two-entry result buffer sits in front of res; rx.ready drops only
// when both entries are full and res is not taking one that cycle.
// Reset (rst, synchronous) returns to the keyword phase, clears link_ready,
// empties the buffer and sets max_length to 65535.
// A framing error is sticky: later bytes are accepted and dropped until reset.
// APB: max_length at address 0, written on the access cycle; pready is high.
module keyword_length_payload_deframer_unit #(
  parameter int LENGTH_BITS = klpd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  klpd_in_if.sink rx,
  klpd_out_if.source res,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [klpd_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [klpd_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [klpd_pkg::APB_DATA_BITS-1:0] prdata,
  output logic pready
);

  logic [klpd_pkg::CFG_BITS-1:0] max_length;
  klpd_pkg::res_push_t push;
  logic can_accept;

  assign rx.ready = can_accept;

  klpd_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .max_length (max_length)
  );

  klpd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (rx.valid & can_accept),
    .rx_byte    (rx.rx_byte),
    .max_length (max_length),
    .push       (push)
  );

  klpd_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .can_accept (can_accept),
    .res        (res)
  );

endmodule

@@ tb/keyword_length_payload_deframer_unit_test.sv @@
module keyword_length_payload_deframer_unit_test;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LENGTH_CAP = (1 << klpd_pkg::LENGTH_BITS_DEFAULT) - 1;
  localparam logic [klpd_pkg::APB_ADDR_BITS-1:0] MAX_LENGTH_ADDR =
    {klpd_pkg::REG_MAX_LENGTH, 2'b00};
  localparam logic [klpd_pkg::APB_ADDR_BITS-1:0] UNUSED_ADDR = 3'd4;
  localparam int RANDOM_SEGMENTS = 4;
  localparam int SEGMENT_BYTES = 385;

  typedef enum logic [1:0] {
    PARSE_KEYWORD,
    PARSE_LENGTH,
    PARSE_PAYLOAD,
    PARSE_ERROR
  } parse_phase_t;

  typedef enum int {
    FAULT_SHORT_KEYWORD,
    FAULT_UNKNOWN_KEYWORD,
    FAULT_LONG_KEYWORD,
    FAULT_BAD_DIGIT,
    FAULT_MANY_DIGITS,
    FAULT_OVER_LIMIT
  } fault_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [klpd_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [klpd_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [klpd_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  klpd_in_if rx_ch ();
  klpd_out_if res_ch ();

  keyword_length_payload_deframer_unit u_top (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .res(res_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  parse_phase_t parse_phase = PARSE_KEYWORD;
  logic [31:0] kw_word = '0;
  logic [2:0] kw_letters = '0;
  logic [klpd_pkg::ACCUM_BITS-1:0] len_accum = '0;
  logic [2:0] len_digits = '0;
  logic [15:0] bytes_left = '0;
  logic [klpd_pkg::KIND_BITS-1:0] frame_kind_q = '0;
  logic link_seen = 1'b0;
  logic [klpd_pkg::CFG_BITS-1:0] max_len_q = klpd_pkg::MAX_LENGTH_RESET;

  klpd_pkg::result_t deframed_due[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned rx_count = 0;
  int unsigned cycles = 0;
  int burst_left = 0;
  int hold_left = 0;
  int stall_span = 0;
  int stall_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  function automatic void restart_keyword();
    parse_phase = PARSE_KEYWORD;
    kw_word = '0;
    kw_letters = '0;
    len_accum = '0;
    len_digits = '0;
  endfunction

  task automatic deframe_byte(input logic [7:0] b);
    klpd_pkg::result_t r;
    bit emit;
    bit hit;
    int unsigned acc;
    r = '0;
    emit = 1'b0;
    hit = 1'b0;
    case (parse_phase)
      PARSE_KEYWORD: begin
        if (b == klpd_pkg::SPACE_CHAR) begin
          if (kw_letters == klpd_pkg::KEYWORD_LETTERS) begin
            for (int k = 0; k < klpd_pkg::KW_COUNT; k++) begin
              if (!hit && klpd_pkg::KEYWORD_TABLE[k] == kw_word) begin
                hit = 1'b1;
                frame_kind_q = klpd_pkg::KIND_BITS'(k);
              end
            end
          end
          if (hit) begin
            parse_phase = PARSE_LENGTH;
            len_accum = '0;
            len_digits = '0;
          end else begin
            emit = 1'b1;
            r.out_kind = klpd_pkg::OUT_ERROR;
          end
        end else if (kw_letters >= klpd_pkg::KEYWORD_LETTERS) begin
          emit = 1'b1;
          r.out_kind = klpd_pkg::OUT_ERROR;
        end else begin
          kw_word = {kw_word[23:0], b};
          kw_letters++;
        end
      end
      PARSE_LENGTH: begin
        if (b >= klpd_pkg::DIGIT_ZERO && b <= klpd_pkg::DIGIT_NINE) begin
          if (len_digits >= klpd_pkg::DIGIT_LIMIT) begin
            emit = 1'b1;
            r.out_kind = klpd_pkg::OUT_ERROR;
            r.frame_kind = frame_kind_q;
          end else begin
            len_digits++;
            acc = len_accum * 10 + (b - klpd_pkg::DIGIT_ZERO);
            len_accum = (acc > klpd_pkg::ACCUM_MAX) ? klpd_pkg::ACCUM_MAX
                                                    : klpd_pkg::ACCUM_BITS'(acc);
          end
        end else if (b != klpd_pkg::SPACE_CHAR || len_accum > max_len_q ||
                     len_accum > LENGTH_CAP) begin
          emit = 1'b1;
          r.out_kind = klpd_pkg::OUT_ERROR;
          r.frame_kind = frame_kind_q;
        end else if (len_accum == 0) begin
          if (frame_kind_q == klpd_pkg::FK_LIST) link_seen = 1'b1;
          emit = 1'b1;
          r.out_kind = klpd_pkg::OUT_EMPTY;
          r.frame_kind = frame_kind_q;
          r.last_byte = 1'b1;
          restart_keyword();
        end else begin
          bytes_left = len_accum[15:0];
          parse_phase = PARSE_PAYLOAD;
        end
      end
      PARSE_PAYLOAD: begin
        bytes_left--;
        emit = 1'b1;
        r.out_kind = klpd_pkg::OUT_PAYLOAD;
        r.frame_kind = frame_kind_q;
        r.data_byte = b;
        r.last_byte = (bytes_left == 0);
        if (bytes_left == 0) begin
          if (frame_kind_q == klpd_pkg::FK_LIST) link_seen = 1'b1;
          restart_keyword();
        end
      end
      default: ;
    endcase
    if (emit) begin
      if (r.out_kind == klpd_pkg::OUT_ERROR) parse_phase = PARSE_ERROR;
      r.link_ready = link_seen;
      deframed_due.push_back(r);
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 19) == 0) gap = $urandom_range(20, 40);
      if (gap > 0) begin
        rx_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    rx_count++;
    deframe_byte(b);
    @(negedge clk);
  endtask

  task automatic drain_results();
    rx_ch.valid <= 1'b0;
    while (deframed_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic apb_write(input logic [klpd_pkg::APB_ADDR_BITS-1:0] addr,
                           input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MAX_LENGTH_ADDR) max_len_q = value[klpd_pkg::CFG_BITS-1:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic apb_read_check(input logic [klpd_pkg::APB_ADDR_BITS-1:0] addr,
                                input logic [31:0] want);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      flag_mismatch($sformatf("register read at %0d: expected %08h, got %08h", addr, want, got));
  endtask

  task automatic send_keyword(input logic [klpd_pkg::KIND_BITS-1:0] k);
    for (int i = 3; i >= 0; i--) send_byte(klpd_pkg::KEYWORD_TABLE[k][8*i +: 8]);
    send_byte(klpd_pkg::SPACE_CHAR);
  endtask

  // Negative pad sends no digits at all.
  task automatic send_length_token(input int unsigned len, input int pad);
    string digits;
    digits = $sformatf("%0d", len);
    if (pad >= 0) begin
      repeat (pad) send_byte(klpd_pkg::DIGIT_ZERO);
      for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
    end
    send_byte(klpd_pkg::SPACE_CHAR);
  endtask

  function automatic logic [7:0] pick_payload();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      2: return klpd_pkg::SPACE_CHAR;
      3: return 8'(klpd_pkg::DIGIT_ZERO + $urandom_range(0, 9));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_frame(input logic [klpd_pkg::KIND_BITS-1:0] k, input int unsigned len,
                            input int pad);
    send_keyword(k);
    send_length_token(len, pad);
    repeat (len) send_byte(pick_payload());
  endtask

  function automatic int unsigned pick_length();
    int unsigned roll;
    int unsigned top;
    roll = $urandom_range(0, 99);
    top = (max_len_q < 12) ? max_len_q : 12;
    if (roll < 12) return 0;
    if (roll < 80) return $urandom_range(1, top);
    top = (max_len_q < 60) ? max_len_q : 60;
    if (roll < 98) return $urandom_range(1, top);
    return (max_len_q < 300) ? max_len_q : $urandom_range(100, 300);
  endfunction

  task automatic send_random_frame();
    int unsigned len;
    int pad;
    string digits;
    len = pick_length();
    digits = $sformatf("%0d", len);
    pad = 0;
    if (len == 0 && $urandom_range(0, 3) == 0) pad = -1;
    else if ($urandom_range(0, 3) == 0) pad = $urandom_range(0, 7 - digits.len());
    send_frame(klpd_pkg::KIND_BITS'($urandom_range(0, klpd_pkg::KW_COUNT - 1)), len, pad);
  endtask

  function automatic logic [7:0] any_but_space();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == klpd_pkg::SPACE_CHAR);
    return b;
  endfunction

  task automatic test_reset_defaults();
    apb_read_check(MAX_LENGTH_ADDR, {16'h0, klpd_pkg::MAX_LENGTH_RESET});
  endtask

  task automatic test_each_keyword();
    send_keyword(klpd_pkg::FK_PING);
    send_length_token(2, 0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(klpd_pkg::FK_PONG, 0, 0);
    send_frame(klpd_pkg::FK_NICK, 0, -1);
    send_frame(klpd_pkg::FK_LIST, 1, 6);
    send_frame(klpd_pkg::FK_CHAT, 1, 0);
    drain_results();
  endtask

  task automatic test_length_limit();
    apb_write(UNUSED_ADDR, 32'd5);
    apb_read_check(MAX_LENGTH_ADDR, {16'h0, max_len_q});
    apb_write(MAX_LENGTH_ADDR, 32'd1);
    apb_read_check(MAX_LENGTH_ADDR, 32'd1);
    send_frame(klpd_pkg::FK_CHAT, 1, 0);
    send_frame(klpd_pkg::FK_PONG, 0, 0);
    drain_results();
  endtask

  // Hold the result side off while a long payload keeps arriving.
  task automatic test_backpressure();
    apb_write(MAX_LENGTH_ADDR, {16'h0, klpd_pkg::MAX_LENGTH_RESET});
    @(posedge clk);
    hold_left = 400;
    @(negedge clk);
    send_frame(klpd_pkg::FK_CHAT, 80, 0);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned stop_at;
    logic [klpd_pkg::CFG_BITS-1:0] setting;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg)
        0: setting = klpd_pkg::MAX_LENGTH_RESET;
        1: setting = klpd_pkg::CFG_BITS'($urandom_range(1, 40));
        2: setting = klpd_pkg::CFG_BITS'($urandom_range(1, 65535));
        default: setting = klpd_pkg::CFG_BITS'(1);
      endcase
      apb_write(MAX_LENGTH_ADDR, {16'h0, setting});
      apb_read_check(MAX_LENGTH_ADDR, {16'h0, setting});
      stop_at = rx_count + SEGMENT_BYTES;
      while (rx_count < stop_at) send_random_frame();
      drain_results();
    end
  endtask

  // The error state is sticky, so only one fault is driven per run.
  task automatic test_framing_error();
    fault_t fault;
    logic [31:0] word;
    bit known;
    int unsigned value;
    logic [7:0] b;
    fault = fault_t'($urandom_range(FAULT_SHORT_KEYWORD, FAULT_OVER_LIMIT));
    case (fault)
      FAULT_SHORT_KEYWORD: begin
        repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(8'h41, 8'h5A)));
        send_byte(klpd_pkg::SPACE_CHAR);
      end
      FAULT_UNKNOWN_KEYWORD: begin
        do begin
          word = {any_but_space(), any_but_space(), any_but_space(), any_but_space()};
          known = 1'b0;
          for (int k = 0; k < klpd_pkg::KW_COUNT; k++)
            if (klpd_pkg::KEYWORD_TABLE[k] == word) known = 1'b1;
        end while (known);
        for (int i = 3; i >= 0; i--) send_byte(word[8*i +: 8]);
        send_byte(klpd_pkg::SPACE_CHAR);
      end
      FAULT_LONG_KEYWORD: begin
        repeat (5) send_byte(any_but_space());
      end
      FAULT_BAD_DIGIT: begin
        send_keyword(klpd_pkg::KIND_BITS'($urandom_range(0, klpd_pkg::KW_COUNT - 1)));
        repeat ($urandom_range(0, 3)) send_byte(8'(klpd_pkg::DIGIT_ZERO + $urandom_range(0, 9)));
        do b = any_but_space();
        while (b >= klpd_pkg::DIGIT_ZERO && b <= klpd_pkg::DIGIT_NINE);
        send_byte(b);
      end
      FAULT_MANY_DIGITS: begin
        send_keyword(klpd_pkg::KIND_BITS'($urandom_range(0, klpd_pkg::KW_COUNT - 1)));
        repeat (8) send_byte(8'(klpd_pkg::DIGIT_ZERO + $urandom_range(0, 9)));
      end
      default: begin
        value = ($urandom_range(0, 3) == 0) ? 9999999 : max_len_q + $urandom_range(1, 1000);
        send_keyword(klpd_pkg::KIND_BITS'($urandom_range(0, klpd_pkg::KW_COUNT - 1)));
        send_length_token(value, 0);
      end
    endcase
    repeat (40) send_byte(8'($urandom_range(0, 255)));
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(20, 120);
        case ($urandom_range(0, 4))
          0, 1: stall_pct = 0;
          2: stall_pct = 25;
          3: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      stall_span--;
      res_ch.ready <= ($urandom_range(1, 100) > stall_pct);
    end
  end

  always @(posedge clk) begin
    klpd_pkg::result_t got;
    klpd_pkg::result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.out_kind = res_ch.out_kind;
      got.frame_kind = res_ch.frame_kind;
      got.data_byte = res_ch.data_byte;
      got.last_byte = res_ch.last_byte;
      got.link_ready = res_ch.link_ready;
      results_seen++;
      if (deframed_due.size() == 0) begin
        flag_mismatch($sformatf("result %0d: none expected, got kind %0d frame %0d byte %02h",
                                results_seen, got.out_kind, got.frame_kind, got.data_byte));
      end else begin
        want = deframed_due.pop_front();
        if (got.out_kind !== want.out_kind || got.frame_kind !== want.frame_kind ||
            got.data_byte !== want.data_byte || got.last_byte !== want.last_byte ||
            got.link_ready !== want.link_ready)
          flag_mismatch($sformatf({"result %0d: expected kind %0d frame %0d byte %02h ",
                                   "last %0d link %0d, got kind %0d frame %0d byte %02h ",
                                   "last %0d link %0d"}, results_seen,
                                  want.out_kind, want.frame_kind, want.data_byte,
                                  want.last_byte, want.link_ready,
                                  got.out_kind, got.frame_kind, got.data_byte,
                                  got.last_byte, got.link_ready));
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst = 1'b1;
    rx_ch.valid = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_defaults();
    test_each_keyword();
    test_length_limit();
    test_backpressure();
    test_random_traffic();
    test_framing_error();
    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
